@@ hdl/rrdl_pkg.sv @@
package rrdl_pkg;

  // Width of every residue, modulus and configuration value.
  localparam int RB = 62;

  // Number of values reduced side by side in the reduction pipeline.
  localparam int NLANE = 3;
  localparam int LANE_INV  = 0;
  localparam int LANE_HALF = 1;
  localparam int LANE_XP   = 2;

  typedef logic [RB-1:0] res_t;

  typedef struct packed {
    res_t kept_residue;
    res_t dropped_residue;
    res_t kept_modulus;
    res_t prime_inverse;
  } in_word_t;

  typedef struct packed {
    res_t new_residue;
    logic status;
  } out_word_t;

  // Values that ride along with the reduction pipeline.
  typedef struct packed {
    res_t xi;
    logic rnd;
    logic bad;
  } side_t;

  typedef enum logic {
    REG_DROPPED_PRIME = 1'b0,
    REG_ROUND_MODE    = 1'b1
  } reg_idx_e;

endpackage

@@ hdl/rrdl_modred.sv @@
module rrdl_modred import rrdl_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [NLANE-1:0][RB-1:0]   val_i,
  input  res_t                       mod_i,
  input  side_t                      side_i,
  output logic                       valid_o,
  output logic [NLANE-1:0][RB-1:0]   rem_o,
  output res_t                       mod_o,
  output side_t                      side_o
);

  // One stage per input bit, most significant first: rem = (2*rem + bit) mod q.
  logic [RB:0]                     v_q;
  logic [NLANE-1:0][RB-1:0]        src_q [RB];
  logic [NLANE-1:0][RB-1:0]        rem_q [RB+1];
  res_t                            mod_q [RB+1];
  side_t                           side_q [RB+1];

  assign v_q[0]    = valid_i;
  assign src_q[0]  = val_i;
  assign rem_q[0]  = '0;
  assign mod_q[0]  = mod_i;
  assign side_q[0] = side_i;

  for (genvar j = 0; j < RB; j++) begin : g_st
    logic [NLANE-1:0][RB-1:0] rem_d;

    for (genvar l = 0; l < NLANE; l++) begin : g_ln
      logic [RB:0] sh;
      logic [RB:0] df;
      assign sh = {rem_q[j][l], src_q[j][l][RB-1-j]};
      assign df = sh - {1'b0, mod_q[j]};
      assign rem_d[l] = (sh >= {1'b0, mod_q[j]}) ? df[RB-1:0] : sh[RB-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j+1]  <= rem_d;
      mod_q[j+1]  <= mod_q[j];
      side_q[j+1] <= side_q[j];
    end

    if (j < RB-1) begin : g_src
      always_ff @(posedge clk_i) begin
        src_q[j+1] <= src_q[j];
      end
    end
  end

  assign valid_o = v_q[RB];
  assign rem_o   = rem_q[RB];
  assign mod_o   = mod_q[RB];
  assign side_o  = side_q[RB];

endmodule

@@ hdl/rrdl_modmul.sv @@
module rrdl_modmul import rrdl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  res_t  a_i,
  input  res_t  b_i,
  input  res_t  mod_i,
  input  logic  bad_i,
  output logic  valid_o,
  output res_t  prod_o,
  output logic  bad_o
);

  // Shift-and-add over the bits of b, most significant first; every partial
  // result is kept below the modulus.
  logic [RB:0] v_q;
  res_t        a_q   [RB];
  res_t        b_q   [RB];
  res_t        r_q   [RB+1];
  res_t        mod_q [RB];
  logic [RB:0] bad_q;

  assign v_q[0]   = valid_i;
  assign a_q[0]   = a_i;
  assign b_q[0]   = b_i;
  assign r_q[0]   = '0;
  assign mod_q[0] = mod_i;
  assign bad_q[0] = bad_i;

  for (genvar j = 0; j < RB; j++) begin : g_st
    logic [RB+1:0] s;
    logic [RB+1:0] m1;
    logic [RB+1:0] m2;
    res_t          r_d;

    assign m1 = {2'b00, mod_q[j]};
    assign m2 = {1'b0, mod_q[j], 1'b0};
    assign s  = {1'b0, r_q[j], 1'b0} + (b_q[j][RB-1-j] ? {2'b00, a_q[j]} : '0);

    always_comb begin
      if (s >= m2) begin
        r_d = RB'(s - m2);
      end else if (s >= m1) begin
        r_d = RB'(s - m1);
      end else begin
        r_d = s[RB-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      r_q[j+1]   <= r_d;
      bad_q[j+1] <= bad_q[j];
    end

    if (j < RB-1) begin : g_ops
      always_ff @(posedge clk_i) begin
        a_q[j+1]   <= a_q[j];
        b_q[j+1]   <= b_q[j];
        mod_q[j+1] <= mod_q[j];
      end
    end
  end

  assign valid_o = v_q[RB];
  assign prod_o  = r_q[RB];
  assign bad_o   = bad_q[RB];

endmodule

@@ hdl/rns_rescale_drop_limb.sv @@
// RNS rescale of one coefficient by a dropped limb prime p.
//
// Input channel: a word is accepted at each rising edge with start_i high
// and busy_o low. busy_o is always low, so a new word may be offered in
// every cycle and the block sustains one word per clock.
// Result channel: done_o is high for exactly one cycle with the result word
// on out_o. The result of a word passes through the RB reduction stages,
// stage A, stage B, the RB multiply stages and the output register.
// Two bit-per-stage pipelines form the bulk: RB stages reduce the
// inverse, the rounding bias and the dropped residue modulo q side by side,
// and RB stages perform the modular multiply by p^-1.
// Configuration: cfg_valid_i with cfg_index_i and cfg_data_i writes
// dropped_prime or round_mode; cfg_ready_o is always high. Registers are
// meant to be changed only while no word is in flight.
// Reset clears every valid bit and loads p = 3 with floor mode. The receiver
// cannot stall, so no back-pressure exists anywhere in the pipeline.
module rns_rescale_drop_limb import rrdl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  in_word_t  in_i,
  output logic      done_o,
  output out_word_t out_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_index_i,
  input  res_t      cfg_data_i
);

  res_t prime_q;
  logic round_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q <= RB'(3);
      round_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_DROPPED_PRIME: prime_q <= cfg_data_i;
        REG_ROUND_MODE:    round_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Entry: range check and the rounding bias on the dropped residue.
  res_t        half;
  logic [RB:0] xp_sum;
  res_t        xp_use;
  logic        accept;
  side_t       side_in;
  logic [NLANE-1:0][RB-1:0] red_in;

  assign accept = start_i && !busy_o;
  assign half   = prime_q >> 1;
  assign xp_sum = {1'b0, in_i.dropped_residue} + {1'b0, half};

  always_comb begin
    xp_use = in_i.dropped_residue;
    if (round_q) begin
      if (xp_sum >= {1'b0, prime_q}) begin
        xp_use = RB'(xp_sum - {1'b0, prime_q});
      end else begin
        xp_use = xp_sum[RB-1:0];
      end
    end
  end

  assign side_in.xi  = in_i.kept_residue;
  assign side_in.rnd = round_q;
  assign side_in.bad = (in_i.kept_residue >= in_i.kept_modulus) ||
                       (in_i.dropped_residue >= prime_q);

  assign red_in[LANE_INV]  = in_i.prime_inverse;
  assign red_in[LANE_HALF] = half;
  assign red_in[LANE_XP]   = xp_use;

  logic                     red_v;
  logic [NLANE-1:0][RB-1:0] red_rem;
  res_t                     red_mod;
  side_t                    red_side;

  rrdl_modred u_red (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .val_i   (red_in),
    .mod_i   (in_i.kept_modulus),
    .side_i  (side_in),
    .valid_o (red_v),
    .rem_o   (red_rem),
    .mod_o   (red_mod),
    .side_o  (red_side)
  );

  // Stage A: add the reduced bias to the kept residue in round mode.
  logic        a_v_q;
  res_t        a_xi_q, a_t_q, a_inv_q, a_mod_q;
  logic        a_bad_q;
  logic [RB:0] xi_sum;
  res_t        xi_d;

  assign xi_sum = {1'b0, red_side.xi} + {1'b0, red_rem[LANE_HALF]};

  always_comb begin
    xi_d = red_side.xi;
    if (red_side.rnd) begin
      if (xi_sum >= {1'b0, red_mod}) begin
        xi_d = RB'(xi_sum - {1'b0, red_mod});
      end else begin
        xi_d = xi_sum[RB-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else begin
      a_v_q <= red_v;
    end
  end

  always_ff @(posedge clk_i) begin
    a_xi_q  <= xi_d;
    a_t_q   <= red_rem[LANE_XP];
    a_inv_q <= red_rem[LANE_INV];
    a_mod_q <= red_mod;
    a_bad_q <= red_side.bad;
  end

  // Stage B: subtract the dropped residue modulo q.
  logic        b_v_q;
  res_t        b_x_q, b_inv_q, b_mod_q;
  logic        b_bad_q;
  logic [RB:0] diff;

  assign diff = (a_xi_q >= a_t_q) ? {1'b0, a_xi_q} - {1'b0, a_t_q}
                                  : {1'b0, a_xi_q} + {1'b0, a_mod_q} - {1'b0, a_t_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_x_q   <= diff[RB-1:0];
    b_inv_q <= a_inv_q;
    b_mod_q <= a_mod_q;
    b_bad_q <= a_bad_q;
  end

  logic mul_v;
  res_t mul_r;
  logic mul_bad;

  rrdl_modmul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (b_v_q),
    .a_i     (b_x_q),
    .b_i     (b_inv_q),
    .mod_i   (b_mod_q),
    .bad_i   (b_bad_q),
    .valid_o (mul_v),
    .prod_o  (mul_r),
    .bad_o   (mul_bad)
  );

  // Output register: a flagged word gives zero with status set.
  logic      done_q;
  out_word_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= mul_v;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q.new_residue <= mul_bad ? '0 : mul_r;
    out_q.status      <= mul_bad;
  end

  assign done_o = done_q;
  assign out_o  = out_q;

endmodule
